/* rtl/vdfl_pkg.sv */
// Shared widths, codes, reset values and types of the descriptor free list.
package vdfl_pkg;

  localparam int QUEUE_SIZE_DEFAULT = 256;
  localparam int NUM_QUEUES_DEFAULT = 2;

  localparam int RING_W     = 9;
  localparam int BUF_LEN_W  = 16;
  localparam int HDR_LEN_W  = 7;
  localparam int PKT_LEN_W  = 16;
  localparam int USED_ID_W  = 16;
  localparam int STATUS_W   = 2;
  localparam int DESC_IDX_W = 8;
  localparam int SLOT_W     = 8;
  localparam int AVAIL_W    = 16;
  localparam int DESC_LEN_W = 17;
  localparam int CURSOR_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Remainder unit works one dividend bit per cycle.
  localparam int REM_STEPS = AVAIL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN = 2'd2;

  localparam logic [RING_W-1:0]    RING_SIZE_RST  = 9'd256;
  localparam logic [RING_W-1:0]    RING_MOD_MAX   = 9'd256;
  localparam logic [RING_W-1:0]    RING_MOD_MIN   = 9'd1;
  localparam logic [BUF_LEN_W-1:0] BUFFER_LEN_RST = 16'd2048;
  localparam logic [HDR_LEN_W-1:0] HEADER_LEN_RST = 7'd10;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ID   = 2'd3;

  localparam logic ACTION_POST    = 1'b0;
  localparam logic ACTION_RECLAIM = 1'b1;

  typedef struct packed {
    logic [RING_W-1:0]    ring_mod;
    logic [BUF_LEN_W-1:0] buffer_len;
    logic [HDR_LEN_W-1:0] header_len;
  } vdfl_cfg_t;

endpackage

/* rtl/vdfl_if.sv */
// Channel interfaces: work items in, results out, register writes.
interface vdfl_item_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic                           queue;
  logic [vdfl_pkg::PKT_LEN_W-1:0] packet_len;
  logic [vdfl_pkg::USED_ID_W-1:0] used_id;

  modport source (output valid, action, queue, packet_len, used_id, input ready);
  modport sink   (input valid, action, queue, packet_len, used_id, output ready);
endinterface

interface vdfl_result_if;
  logic                            valid;
  logic                            ready;
  logic [vdfl_pkg::STATUS_W-1:0]   status;
  logic [vdfl_pkg::DESC_IDX_W-1:0] desc_index;
  logic [vdfl_pkg::SLOT_W-1:0]     avail_slot;
  logic [vdfl_pkg::AVAIL_W-1:0]    avail_count;
  logic [vdfl_pkg::DESC_LEN_W-1:0] desc_len;
  logic [vdfl_pkg::CURSOR_W-1:0]   used_cursor;

  modport source (output valid, status, desc_index, avail_slot, avail_count, desc_len,
                  used_cursor, input ready);
  modport sink   (input valid, status, desc_index, avail_slot, avail_count, desc_len,
                  used_cursor, output ready);
endinterface

interface vdfl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vdfl_pkg::CFG_IDX_W-1:0]  index;
  logic [vdfl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/vdfl_link_ram.sv */
// Next-pointer memory of the free lists, one write and one registered read port.
module vdfl_link_ram #(
  parameter int QUEUE_SIZE = vdfl_pkg::QUEUE_SIZE_DEFAULT,
  parameter int NUM_QUEUES = vdfl_pkg::NUM_QUEUES_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [$clog2(NUM_QUEUES*QUEUE_SIZE)-1:0]  wr_addr,
  input  logic [$clog2(QUEUE_SIZE+1)-1:0]           wr_data,
  input  logic                                      rd_en,
  input  logic [$clog2(NUM_QUEUES*QUEUE_SIZE)-1:0]  rd_addr,
  output logic [$clog2(QUEUE_SIZE+1)-1:0]           rd_data
);
  import vdfl_pkg::*;

  localparam int DEPTH = NUM_QUEUES * QUEUE_SIZE;
  localparam int LW    = $clog2(QUEUE_SIZE + 1);

  logic [LW-1:0] links [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      links[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= links[rd_addr];
    end
  end

endmodule

/* rtl/vdfl_rem_unit.sv */
// Serial remainder: dividend mod divisor, one dividend bit per cycle.
module vdfl_rem_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vdfl_pkg::AVAIL_W-1:0]  dividend,
  input  logic [vdfl_pkg::RING_W-1:0]   divisor,
  output logic                          done,
  output logic [vdfl_pkg::SLOT_W-1:0]   rem
);
  import vdfl_pkg::*;

  localparam int CW = $clog2(REM_STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [AVAIL_W-1:0] shift;
  logic [RING_W-1:0]  trial;
  logic [SLOT_W-1:0]  rem_next;

  // Remainder stays below the divisor (at most 256), so the trial fits 9 bits.
  always_comb begin
    trial = {rem, shift[AVAIL_W-1]};
    if (trial >= divisor) begin
      rem_next = SLOT_W'(trial - divisor);
    end else begin
      rem_next = SLOT_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(REM_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shift <= dividend;
    end else if (busy) begin
      rem   <= rem_next;
      shift <= {shift[AVAIL_W-2:0], 1'b0};
    end
  end

endmodule

/* rtl/vdfl_cfg_regs.sv */
// Configuration registers with the clamped ring modulus.
module vdfl_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                open,
  vdfl_cfg_if.sink            cfg,
  output logic                ring_write,
  output vdfl_pkg::vdfl_cfg_t cfg_val
);
  import vdfl_pkg::*;

  logic [RING_W-1:0]    ring_size;
  logic [BUF_LEN_W-1:0] buffer_len;
  logic [HDR_LEN_W-1:0] header_len;
  logic                 wr;

  assign cfg.ready  = open;
  assign wr         = cfg.valid && open;
  assign ring_write = wr && (cfg.index == CFG_RING_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size  <= RING_SIZE_RST;
      buffer_len <= BUFFER_LEN_RST;
      header_len <= HEADER_LEN_RST;
    end else if (wr) begin
      case (cfg.index)
        CFG_RING_SIZE:  ring_size  <= cfg.data[RING_W-1:0];
        CFG_BUFFER_LEN: buffer_len <= cfg.data[BUF_LEN_W-1:0];
        CFG_HEADER_LEN: header_len <= cfg.data[HDR_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything past 256 acts as 256.
  always_comb begin
    if (ring_size == '0) begin
      cfg_val.ring_mod = RING_MOD_MIN;
    end else if (ring_size > RING_MOD_MAX) begin
      cfg_val.ring_mod = RING_MOD_MAX;
    end else begin
      cfg_val.ring_mod = ring_size;
    end
    cfg_val.buffer_len = buffer_len;
    cfg_val.header_len = header_len;
  end

endmodule

/* rtl/virtqueue_descriptor_free_list.sv */
// Top level: split-virtqueue descriptor free lists with avail and used cursors.
//
// Channels: "item" carries post (pop a descriptor for a packet) and reclaim
// (push a used descriptor back) requests; "result" returns one result per item;
// "cfg" writes ring_size (0), buffer_len (1) and header_len (2).
// Each queue's free list is a LIFO chain held in a next-pointer RAM with a
// registered read port. The accept cycle reads the link at the list head; the
// execute state updates the list and loads the result register. The result
// appears in the cycle after that; the next item can be taken while the result
// still waits.
// When the receiver stalls, the finished item is held in its execute cycle
// until the result register frees up; item.ready stays low meanwhile.
// Reset: the RAM is chained 0,1,2,... within each queue by a clearing pass over
// NUM_QUEUES*QUEUE_SIZE entries (512 by default); items wait, cfg writes go on.
// A ring_size write recomputes every queue's avail slot and reduced used cursor
// with two serial remainder units, one queue after another, with item.ready low.
// cfg.ready is high only while no item is in flight.
module virtqueue_descriptor_free_list #(
  parameter int QUEUE_SIZE = vdfl_pkg::QUEUE_SIZE_DEFAULT,
  parameter int NUM_QUEUES = vdfl_pkg::NUM_QUEUES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  vdfl_item_if.sink      item,
  vdfl_result_if.source  result,
  vdfl_cfg_if.sink       cfg
);
  import vdfl_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IW = $clog2(QUEUE_SIZE);
  localparam int LW = $clog2(QUEUE_SIZE + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_SIZE);
  localparam logic [LW-1:0] LINK_NONE = LW'(QUEUE_SIZE);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FIX_START,
    S_FIX_WAIT
  } state_t;

  state_t state;

  // Per-queue cursors, small enough for flops. used is the reported cursor,
  // which keeps its value across a ring_size change until the next reclaim;
  // used_red is the same cursor reduced by the current ring size.
  logic [LW-1:0]       head     [NUM_QUEUES];
  logic [AVAIL_W-1:0]  avail    [NUM_QUEUES];
  logic [SLOT_W-1:0]   slot     [NUM_QUEUES];
  logic [CURSOR_W-1:0] used     [NUM_QUEUES];
  logic [CURSOR_W-1:0] used_red [NUM_QUEUES];

  logic [QW-1:0] init_q;
  logic [IW-1:0] init_i;
  logic [QW-1:0] fix_q;

  // Latched item.
  logic                 action_r;
  logic [QW-1:0]        q_r;
  logic [PKT_LEN_W-1:0] plen_r;
  logic [USED_ID_W-1:0] uid_r;

  logic res_valid;

  vdfl_cfg_t cfg_val;
  logic      ring_write;
  logic      cfg_open;

  logic          item_acc;
  logic          exec_fire;
  logic [QW-1:0] qsel;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [LW-1:0] mem_rdata;

  logic                  rem_start;
  logic                  done_slot;
  logic                  done_used;
  logic                  rem_done;
  logic [SLOT_W-1:0]     rem_slot;
  logic [SLOT_W-1:0]     rem_used;

  // Execute-stage results.
  logic [LW-1:0]         head_cur;
  logic [AVAIL_W-1:0]    avail_cur;
  logic [SLOT_W-1:0]     slot_cur;
  logic [CURSOR_W-1:0]   used_cur;
  logic [CURSOR_W-1:0]   used_red_cur;
  logic [LW-1:0]         head_next;
  logic [AVAIL_W-1:0]    avail_next;
  logic [SLOT_W-1:0]     slot_next;
  logic [CURSOR_W-1:0]   used_next;
  logic [CURSOR_W-1:0]   used_red_next;
  logic [STATUS_W-1:0]   status_next;
  logic [DESC_IDX_W-1:0] didx_next;
  logic [DESC_LEN_W-1:0] dlen_next;
  logic                  exec_we;
  logic [AW-1:0]         exec_waddr;
  logic [LW-1:0]         exec_wdata;

  function automatic logic [AW-1:0] link_addr(input logic [QW-1:0] q,
                                               input logic [IW-1:0] i);
    link_addr = AW'(q) * AW'(QUEUE_SIZE) + AW'(i);
  endfunction

  vdfl_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .open       (cfg_open),
    .cfg        (cfg),
    .ring_write (ring_write),
    .cfg_val    (cfg_val)
  );

  vdfl_link_ram #(
    .QUEUE_SIZE (QUEUE_SIZE),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_links (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (item_acc),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  vdfl_rem_unit u_rem_slot (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (avail[fix_q]),
    .divisor  (cfg_val.ring_mod),
    .done     (done_slot),
    .rem      (rem_slot)
  );

  vdfl_rem_unit u_rem_used (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (AVAIL_W'(used[fix_q])),
    .divisor  (cfg_val.ring_mod),
    .done     (done_used),
    .rem      (rem_used)
  );

  // Handshakes: config only while nothing is in flight, and it wins over items.
  assign cfg_open   = (state == S_INIT) || (state == S_IDLE);
  assign item.ready = (state == S_IDLE) && !cfg.valid;
  assign item_acc   = item.valid && item.ready;
  assign exec_fire  = (state == S_EXEC) && (!res_valid || result.ready);
  assign rem_start  = (state == S_FIX_START);
  assign rem_done   = done_slot && done_used;

  // Queue number past the count folds back; with one queue everything is queue 0.
  assign qsel      = (NUM_QUEUES > 1) ? QW'(item.queue) : '0;
  assign mem_raddr = link_addr(qsel, head[qsel][IW-1:0]);

  // Write port: clearing pass chains i -> i+1, the last entry gets "none".
  always_comb begin
    if (state == S_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = link_addr(init_q, init_i);
      mem_wdata = LW'(init_i) + LW'(1);
    end else begin
      mem_we    = exec_we && exec_fire;
      mem_waddr = exec_waddr;
      mem_wdata = exec_wdata;
    end
  end

  // Execute: pop or push, then advance the cursors.
  always_comb begin
    head_cur      = head[q_r];
    avail_cur     = avail[q_r];
    slot_cur      = slot[q_r];
    used_cur      = used[q_r];
    used_red_cur  = used_red[q_r];
    head_next     = head_cur;
    avail_next    = avail_cur;
    slot_next     = slot_cur;
    used_next     = used_cur;
    used_red_next = used_red_cur;
    status_next   = STATUS_OK;
    didx_next     = '0;
    dlen_next     = '0;
    exec_we       = 1'b0;
    exec_waddr    = link_addr(q_r, head_cur[IW-1:0]);
    exec_wdata    = LINK_NONE;
    if (action_r == ACTION_POST) begin
      if (head_cur == LINK_NONE) begin
        status_next = STATUS_EMPTY;
      end else if (plen_r > cfg_val.buffer_len) begin
        status_next = STATUS_TOO_LONG;
        didx_next   = DESC_IDX_W'(head_cur);
        dlen_next   = DESC_LEN_W'(cfg_val.buffer_len);
      end else begin
        // Unlink the head: its successor comes from the RAM read.
        exec_we    = 1'b1;
        head_next  = mem_rdata;
        didx_next  = DESC_IDX_W'(head_cur);
        dlen_next  = DESC_LEN_W'(cfg_val.header_len) + DESC_LEN_W'(plen_r);
        avail_next = avail_cur + AVAIL_W'(1);
        // The 16-bit count wraps to zero, and so does its remainder.
        if (avail_next == '0) begin
          slot_next = '0;
        end else if (RING_W'(slot_cur) + RING_W'(1) == cfg_val.ring_mod) begin
          slot_next = '0;
        end else begin
          slot_next = slot_cur + SLOT_W'(1);
        end
      end
    end else begin
      if ({1'b0, uid_r} < (USED_ID_W + 1)'(QUEUE_SIZE)) begin
        exec_we    = 1'b1;
        exec_waddr = link_addr(q_r, uid_r[IW-1:0]);
        exec_wdata = head_cur;
        head_next  = LW'(uid_r[IW-1:0]);
        didx_next  = DESC_IDX_W'(uid_r);
        dlen_next  = DESC_LEN_W'(cfg_val.buffer_len);
      end else begin
        status_next = STATUS_BAD_ID;
      end
      // A bad id still consumes its used ring entry; advance from the reduced copy.
      if (RING_W'(used_red_cur) + RING_W'(1) == cfg_val.ring_mod) begin
        used_next = '0;
      end else begin
        used_next = used_red_cur + CURSOR_W'(1);
      end
      used_red_next = used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_q    <= '0;
      init_i    <= '0;
      fix_q     <= '0;
      res_valid <= 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head[q]     <= '0;
        avail[q]    <= '0;
        slot[q]     <= '0;
        used[q]     <= '0;
        used_red[q] <= '0;
      end
    end else begin
      if (exec_fire) begin
        res_valid          <= 1'b1;
        result.status      <= status_next;
        result.desc_index  <= didx_next;
        result.avail_slot  <= slot_cur;
        result.avail_count <= avail_next;
        result.desc_len    <= dlen_next;
        result.used_cursor <= used_next;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (item_acc) begin
        action_r <= item.action;
        q_r      <= qsel;
        plen_r   <= item.packet_len;
        uid_r    <= item.used_id;
      end
      case (state)
        S_INIT: begin
          if (init_i == IW'(QUEUE_SIZE - 1)) begin
            init_i <= '0;
            if (init_q == QW'(NUM_QUEUES - 1)) begin
              state <= S_IDLE;
            end else begin
              init_q <= init_q + QW'(1);
            end
          end else begin
            init_i <= init_i + IW'(1);
          end
        end
        S_IDLE: begin
          if (ring_write) begin
            fix_q <= '0;
            state <= S_FIX_START;
          end else if (item_acc) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            head[q_r]     <= head_next;
            avail[q_r]    <= avail_next;
            slot[q_r]     <= slot_next;
            used[q_r]     <= used_next;
            used_red[q_r] <= used_red_next;
            state         <= S_IDLE;
          end
        end
        S_FIX_START: begin
          state <= S_FIX_WAIT;
        end
        S_FIX_WAIT: begin
          if (rem_done) begin
            slot[fix_q]     <= rem_slot;
            used_red[fix_q] <= rem_used;
            if (fix_q == QW'(NUM_QUEUES - 1)) begin
              state <= S_IDLE;
            end else begin
              fix_q <= fix_q + QW'(1);
              state <= S_FIX_START;
            end
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  assign result.valid = res_valid;

  // Cursors must stay reduced by the current modulus whenever an item executes.
  a_slot_reduced: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> (RING_W'(slot[q_r]) < cfg_val.ring_mod))
    else $error("avail slot not reduced by ring size");

  a_used_reduced: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> (RING_W'(used_red[q_r]) < cfg_val.ring_mod))
    else $error("used cursor not reduced by ring size");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_EXEC)
    else $error("result loaded outside the execute cycle");

endmodule

/* tb/vdfl_result_checker.sv */
// Result checker for the descriptor free list: predicts every result and compares it.
module vdfl_result_checker (
  input  logic   clk,
  input  logic   rst,
  vdfl_item_if   item,
  vdfl_result_if result,
  vdfl_cfg_if    cfg,
  output int     fail_count,
  output int     pending,
  output int     results_seen
);
  import vdfl_pkg::*;

  localparam int NDESC    = QUEUE_SIZE_DEFAULT;
  localparam int NQ       = NUM_QUEUES_DEFAULT;
  localparam int LINK_END = NDESC;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [DESC_IDX_W-1:0] desc_index;
    logic [SLOT_W-1:0]     avail_slot;
    logic [AVAIL_W-1:0]    avail_count;
    logic [DESC_LEN_W-1:0] desc_len;
    logic [CURSOR_W-1:0]   used_cursor;
  } outcome_t;

  // Shadow of the free lists, cursors and registers.
  int unsigned          link_tbl [NQ*NDESC];
  int unsigned          list_head [NQ];
  logic [AVAIL_W-1:0]   avail_idx [NQ];
  int unsigned          used_pos [NQ];
  logic [RING_W-1:0]    ring_reg;
  logic [BUF_LEN_W-1:0] buf_reg;
  logic [HDR_LEN_W-1:0] hdr_reg;

  outcome_t due_q [$];
  outcome_t want;

  // Apply one work item to the shadow state and return the result it owes.
  function automatic outcome_t serve(input logic act, input logic q_sel,
                                     input logic [PKT_LEN_W-1:0] plen,
                                     input logic [USED_ID_W-1:0] uid);
    int unsigned q;
    int unsigned modv;
    int unsigned base;
    int unsigned h;
    outcome_t r;
    q    = q_sel % NQ;
    base = q * NDESC;
    if (ring_reg == 0) modv = RING_MOD_MIN;
    else if (ring_reg > RING_MOD_MAX) modv = RING_MOD_MAX;
    else modv = ring_reg;
    r            = '0;
    r.status     = STATUS_OK;
    r.avail_slot = SLOT_W'(avail_idx[q] % modv);
    if (act == ACTION_POST) begin
      h = list_head[q];
      if (h >= NDESC) begin
        r.status = STATUS_EMPTY;
      end else if (plen > buf_reg) begin
        r.status     = STATUS_TOO_LONG;
        r.desc_index = DESC_IDX_W'(h);
        r.desc_len   = DESC_LEN_W'(buf_reg);
      end else begin
        list_head[q]     = link_tbl[base + h];
        link_tbl[base + h] = LINK_END;
        r.desc_index     = DESC_IDX_W'(h);
        r.desc_len       = DESC_LEN_W'(hdr_reg) + DESC_LEN_W'(plen);
        avail_idx[q]     = avail_idx[q] + 1'b1;
      end
    end else begin
      if (uid >= NDESC) begin
        r.status = STATUS_BAD_ID;
      end else begin
        link_tbl[base + uid] = list_head[q];
        list_head[q]         = uid;
        r.desc_index         = DESC_IDX_W'(uid);
        r.desc_len           = DESC_LEN_W'(buf_reg);
      end
      // The used entry is consumed even when its id is rejected.
      used_pos[q] = (used_pos[q] + 1) % modv;
    end
    r.avail_count = avail_idx[q];
    r.used_cursor = CURSOR_W'(used_pos[q]);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NQ*NDESC; k++)
        link_tbl[k] = ((k % NDESC) + 1 < NDESC) ? (k % NDESC) + 1 : LINK_END;
      for (int k = 0; k < NQ; k++) begin
        list_head[k] = 0;
        avail_idx[k] = '0;
        used_pos[k]  = 0;
      end
      ring_reg     = RING_SIZE_RST;
      buf_reg      = BUFFER_LEN_RST;
      hdr_reg      = HEADER_LEN_RST;
      due_q.delete();
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_RING_SIZE:  ring_reg = cfg.data[RING_W-1:0];
          CFG_BUFFER_LEN: buf_reg  = cfg.data[BUF_LEN_W-1:0];
          CFG_HEADER_LEN: hdr_reg  = cfg.data[HDR_LEN_W-1:0];
          default: ;
        endcase
      end
      // Compare before predicting: a result never belongs to the item taken at the same edge.
      if (result.valid && result.ready) begin
        results_seen++;
        if (due_q.size() == 0) begin
          $error("result with no item outstanding: status %0d desc_index %0d",
                 result.status, result.desc_index);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          check_field("status", want.status, result.status);
          check_field("desc_index", want.desc_index, result.desc_index);
          check_field("avail_slot", want.avail_slot, result.avail_slot);
          check_field("avail_count", want.avail_count, result.avail_count);
          check_field("desc_len", want.desc_len, result.desc_len);
          check_field("used_cursor", want.used_cursor, result.used_cursor);
        end
      end
      if (item.valid && item.ready)
        due_q.push_back(serve(item.action, item.queue, item.packet_len, item.used_id));
      pending = due_q.size();
    end
  end

endmodule

/* tb/tb_virtqueue_descriptor_free_list.sv */
// Testbench top for the descriptor free list: stimulus, handshake pacing and verdict.
module tb_virtqueue_descriptor_free_list;
  import vdfl_pkg::*;

  localparam int NDESC          = QUEUE_SIZE_DEFAULT;
  localparam int IDLE_PCT       = 35;
  // Longest legal quiet stretch is the reset clearing pass.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk;
  logic rst;
  logic sink_ready = 1'b0;
  bit   steady     = 1'b0;   // high: neither side idles

  int idle_cycles = 0;
  int items_sent  = 0;
  int regs_written = 0;
  int mismatch_cnt;
  int pending_cnt;
  int results_cnt;

  // Stimulus-side mirror of each free list. As long as only outstanding
  // descriptors are reclaimed, the list is a plain stack: pop on a good post,
  // push on a reclaim. It steers reclaims toward valid ids; it checks nothing.
  int free_ids [2][$];
  int held_ids [2][$];
  logic [BUF_LEN_W-1:0] cur_buf;

  vdfl_item_if   item_ch ();
  vdfl_result_if result_ch ();
  vdfl_cfg_if    cfg_ch ();

  assign result_ch.ready = sink_ready;

  virtqueue_descriptor_free_list DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  vdfl_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (result_ch),
    .cfg          (cfg_ch),
    .fail_count   (mismatch_cnt),
    .pending      (pending_cnt),
    .results_seen (results_cnt)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: stall about a third of the cycles unless the steady window is on.
  always @(negedge clk)
    sink_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

  // Watchdog: end the run if no channel transfers for too long.
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("virtqueue_descriptor_free_list regression: fail");
      $finish;
    end
  end

  // Present one item and hold it until the transfer. Entered and left at a
  // falling edge; valid is only lowered for an idle gap, so a back-to-back
  // item keeps valid high without a second assignment in the same step.
  task automatic send_item(input logic act, input logic q,
                           input logic [PKT_LEN_W-1:0] plen,
                           input logic [USED_ID_W-1:0] uid);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.action     <= act;
    item_ch.queue      <= q;
    item_ch.packet_len <= plen;
    item_ch.used_id    <= uid;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Packet length that fits the current buffer, biased to both ends.
  function automatic logic [PKT_LEN_W-1:0] fit_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return cur_buf;
      default: return PKT_LEN_W'($urandom_range(0, int'(cur_buf)));
    endcase
  endfunction

  task automatic post(input logic q, input logic [PKT_LEN_W-1:0] plen);
    if (free_ids[q].size() > 0 && plen <= cur_buf)
      held_ids[q].push_back(free_ids[q].pop_front());
    send_item(ACTION_POST, q, plen, USED_ID_W'($urandom));
  endtask

  task automatic reclaim_id(input logic q, input int id);
    int spot;
    spot = -1;
    for (int k = 0; k < held_ids[q].size(); k++)
      if (held_ids[q][k] == id) spot = k;
    if (spot >= 0) begin
      held_ids[q].delete(spot);
      free_ids[q].push_front(id);
    end
    send_item(ACTION_RECLAIM, q, PKT_LEN_W'($urandom), USED_ID_W'(id));
  endtask

  task automatic reclaim_bad(input logic q);
    logic [USED_ID_W-1:0] uid;
    uid = ($urandom_range(0, 3) == 0) ? USED_ID_W'(NDESC)
                                      : USED_ID_W'($urandom_range(NDESC, 65535));
    send_item(ACTION_RECLAIM, q, PKT_LEN_W'($urandom), uid);
  endtask

  // Well-formed traffic: posts and reclaims of outstanding descriptors,
  // with some oversized packets and bad used ids mixed in.
  task automatic random_item(input logic q);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      reclaim_bad(q);
    else if (r < 16 && cur_buf != '1)
      post(q, PKT_LEN_W'($urandom_range(int'(cur_buf) + 1, 65535)));
    else if (r < 58 || held_ids[q].size() == 0)
      post(q, fit_len());
    else
      reclaim_id(q, held_ids[q][$urandom_range(0, held_ids[q].size() - 1)]);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    regs_written++;
  endtask

  // Reprogram all three registers with the block drained.
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] ring,
                                input logic [CFG_DATA_W-1:0] buf_len,
                                input logic [CFG_DATA_W-1:0] hdr);
    settle();
    write_reg(CFG_RING_SIZE, ring);
    write_reg(CFG_BUFFER_LEN, buf_len);
    write_reg(CFG_HEADER_LEN, hdr);
    cfg_ch.valid <= 1'b0;
    cur_buf = buf_len;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      random_item(1'($urandom));
      // Pressure: once per phase let the pipeline drain completely.
      if (i == n / 2) settle();
    end
  endtask

  // Broken sequences: reclaims of descriptors already free, double reclaims
  // and raw random fields. The stack mirror is no longer trusted afterwards.
  task automatic run_noise(input int n);
    logic q;
    int   id;
    for (int i = 0; i < n; i++) begin
      q = 1'($urandom);
      case ($urandom_range(0, 3))
        0: send_item(ACTION_POST, q, PKT_LEN_W'($urandom_range(0, 3)), USED_ID_W'($urandom));
        1: send_item(ACTION_RECLAIM, q, PKT_LEN_W'($urandom),
                     USED_ID_W'($urandom_range(0, NDESC - 1)));
        2: begin
          if (held_ids[q].size() > 0) begin
            id = held_ids[q][0];
            reclaim_id(q, id);
            reclaim_id(q, id);
          end else begin
            reclaim_id(q, $urandom_range(0, NDESC - 1));
          end
        end
        default: send_item(1'($urandom), q, PKT_LEN_W'($urandom), USED_ID_W'($urandom));
      endcase
    end
  endtask

  initial begin
    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.action     <= ACTION_POST;
    item_ch.queue      <= 1'b0;
    item_ch.packet_len <= '0;
    item_ch.used_id    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_RING_SIZE;
    cfg_ch.data        <= '0;
    cur_buf             = BUFFER_LEN_RST;
    for (int i = 0; i < NDESC; i++) begin
      free_ids[0].push_back(i);
      free_ids[1].push_back(i);
    end
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at reset settings (ring 256, buffer 2048, header 10).
    // Items queue up behind the clearing pass; the first ones prove it finished.
    post(1'b0, 16'd0);                   // shortest packet, descriptor 0
    post(1'b0, 16'd2048);                // exactly the buffer length
    post(1'b0, 16'd2049);                // one byte too long
    post(1'b0, 16'hFFFF);                // longest packet, rejected
    post(1'b1, 16'd1234);                // second queue starts at descriptor 0
    reclaim_id(1'b0, 1);
    post(1'b0, 16'd7);                   // LIFO: the descriptor just pushed comes back
    send_item(ACTION_RECLAIM, 1'b0, 16'd0, USED_ID_W'(NDESC));  // first bad id
    send_item(ACTION_RECLAIM, 1'b1, 16'hFFFF, 16'hFFFF);        // largest bad id
    reclaim_id(1'b1, 0);
    reclaim_id(1'b0, 0);
    reclaim_id(1'b0, 1);
    post(1'b1, 16'h5555);
    post(1'b1, 16'h02AA);

    // Ring of one slot, largest buffer and a header of 64: drain queue 1 to empty,
    // post into the empty list, then hand every descriptor back.
    apply_settings(16'd1, 16'hFFFF, 16'd64);
    post(1'b1, 16'hFFFF);
    while (free_ids[1].size() > 0) begin
      if ($urandom_range(0, 7) == 0) random_item(1'b0);
      else post(1'b1, PKT_LEN_W'($urandom));
    end
    repeat (3) post(1'b1, PKT_LEN_W'($urandom));
    reclaim_bad(1'b1);
    while (held_ids[1].size() > 0) begin
      if ($urandom_range(0, 7) == 0) random_item(1'b0);
      else reclaim_id(1'b1, held_ids[1][$urandom_range(0, held_ids[1].size() - 1)]);
    end

    // Ring size zero acts as one; a one-byte buffer, no header.
    apply_settings(16'd0, 16'd1, 16'd0);
    run_random(100);

    // Odd ring size with no idling on either side.
    apply_settings(16'd7, 16'd1500, 16'd12);
    steady = 1'b1;
    run_random(150);
    steady = 1'b0;

    // Ring size above 256 clamps; all data bits set makes the header 127.
    apply_settings(16'd300, 16'($urandom_range(1, 65534)), 16'hFFFF);
    run_random(150);

    // High data bits are dropped: 0x300 leaves 256. Then touch the unmapped index.
    apply_settings(16'h0300, 16'd2048, 16'd10);
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_ch.valid <= 1'b0;
    run_random(100);

    // Random ring size, possibly smaller than the current used cursor.
    apply_settings(16'($urandom_range(2, 255)), 16'($urandom_range(100, 20000)),
                   16'($urandom_range(0, 64)));
    run_random(150);

    // Largest ring field and a zero-length buffer for the broken sequences.
    apply_settings(16'd511, 16'd0, 16'd64);
    run_noise(80);

    // Drain and let any trailing activity settle before the verdict.
    item_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d items and %0d register writes across eight register settings,",
             items_sent, regs_written);
    $display("including a drained and refilled free list; %0d results checked, %0d mismatches.",
             results_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("virtqueue_descriptor_free_list regression: pass");
    else
      $display("virtqueue_descriptor_free_list regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/vdfl_pkg.sv
rtl/vdfl_if.sv
rtl/vdfl_link_ram.sv
rtl/vdfl_rem_unit.sv
rtl/vdfl_cfg_regs.sv
rtl/virtqueue_descriptor_free_list.sv
tb/vdfl_result_checker.sv
tb/tb_virtqueue_descriptor_free_list.sv
